// ===== rtl/rv64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv64_pkg
// Shared types and constants for the RV64IM execute core.
// ----------------------------------------------------------------------------
package rv64_pkg;

    localparam int XLEN   = 64;
    localparam int NREG   = 32;
    localparam int REG_AW = 5;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_IMM32  = 7'h1B;
    localparam logic [6:0] OPC_OP32   = 7'h3B;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [5:0] F6_SRL    = 6'h00;
    localparam logic [5:0] F6_SRA    = 6'h10;

    localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INS_MRET   = 32'h3020_0073;

    localparam logic [11:0] CSR_SATP    = 12'h180;
    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;

    localparam logic [REG_AW-1:0] REG_A0 = 5'd10;
    localparam logic [REG_AW-1:0] REG_A7 = 5'd17;

    typedef enum logic [2:0] {
        ST_OK, ST_LOAD, ST_ECALL, ST_HALT, ST_ILLEGAL, ST_CSR_UNK
    } status_t;

    typedef enum logic [1:0] {
        MEM_NONE, MEM_READ, MEM_WRITE
    } memop_t;

    typedef enum logic [2:0] {
        CSR_IDX_SATP, CSR_IDX_MSTATUS, CSR_IDX_MEPC, CSR_IDX_MCAUSE, CSR_IDX_MTVEC,
        CSR_IDX_NONE
    } csr_idx_t;

    typedef struct packed {
        logic latch;
        logic read;
        logic md_start;
        logic wb;
    } dp_cmd_t;

    typedef struct packed {
        logic md_need;
        logic md_done;
    } dp_stat_t;

    typedef struct packed {
        logic [XLEN-1:0] halt_code;
        logic [XLEN-1:0] store_data;
        logic [3:0]      mem_bytes;
        logic [XLEN-1:0] mem_addr;
        memop_t          mem_op;
        logic [XLEN-1:0] next_pc;
        status_t         status;
    } result_t;

    function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rv64_md.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv64_md
// Iterative unsigned 64x64 multiplier / 64/64 divider, one bit per cycle.
// ----------------------------------------------------------------------------
module rv64_md
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic                    is_div,
    input  wire logic [rv64_pkg::XLEN-1:0] opa,
    input  wire logic [rv64_pkg::XLEN-1:0] opb,
    output logic                         done,
    output logic [rv64_pkg::XLEN-1:0]    hi,
    output logic [rv64_pkg::XLEN-1:0]    lo
);
    import rv64_pkg::*;

    logic            busy_reg;
    logic            div_reg;
    logic [5:0]      cnt_reg;
    logic [XLEN-1:0] op_reg;
    logic [XLEN-1:0] hi_reg;
    logic [XLEN-1:0] lo_reg;
    logic [XLEN:0]   mul_sum;
    logic [XLEN:0]   div_sh;
    logic [XLEN:0]   div_diff;
    logic            div_ge;

    // multiply: hi accumulates, lo shifts out multiplier bits
    // divide: hi is partial remainder, lo shifts in quotient bits
    always_comb
    begin
        mul_sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, op_reg} : '0);
        div_sh   = {hi_reg, lo_reg[XLEN-1]};
        div_diff = div_sh - {1'b0, op_reg};
        div_ge   = div_sh >= {1'b0, op_reg};
    end

    assign done = busy_reg && (cnt_reg == 6'(XLEN - 1));
    assign hi   = hi_reg;
    assign lo   = lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= is_div;
            op_reg  <= is_div ? opb : opa;
            hi_reg  <= '0;
            lo_reg  <= is_div ? opa : opb;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                hi_reg <= div_ge ? div_diff[XLEN-1:0] : div_sh[XLEN-1:0];
                lo_reg <= {lo_reg[XLEN-2:0], div_ge};
            end
            else
            begin
                hi_reg <= mul_sum[XLEN:1];
                lo_reg <= {mul_sum[0], lo_reg[XLEN-1:1]};
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rv64_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv64_dp
// Datapath: register file, CSRs, decode/ALU, mul/div unit, result register.
// ----------------------------------------------------------------------------
module rv64_dp
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rv64_pkg::dp_cmd_t        cmd,
    output rv64_pkg::dp_stat_t            stat,
    input  wire logic                     req_type,
    input  wire logic [31:0]              instr_word,
    input  wire logic [rv64_pkg::XLEN-1:0] pc_value,
    input  wire logic [rv64_pkg::XLEN-1:0] load_data,
    output rv64_pkg::result_t             res
);
    import rv64_pkg::*;

    // input word and operands
    logic            req_reg;
    logic [31:0]     ins_reg;
    logic [XLEN-1:0] pc_reg;
    logic [XLEN-1:0] ld_reg;
    logic [XLEN-1:0] a_reg;
    logic [XLEN-1:0] b_reg;

    // architectural state
    logic [XLEN-1:0]   rf [NREG];
    logic [NREG-1:0]   rf_vld_reg;
    logic [XLEN-1:0]   satp_reg, mstatus_reg, mepc_reg, mcause_reg, mtvec_reg;
    logic              ldp_reg;
    logic [REG_AW-1:0] ldd_reg;
    logic [2:0]        lds_reg;
    result_t           res_reg;

    // decode fields
    logic [6:0]        op, f7;
    logic [2:0]        f3;
    logic [REG_AW-1:0] rd, rs1, rs2, rb_addr;
    logic [XLEN-1:0]   imm_i, imm_s, imm_b, imm_u, imm_j;

    // mul/div
    logic            md_done;
    logic [XLEN-1:0] md_hi, md_lo;
    logic            md_w, md_sa, md_sb, md_bz;
    logic [XLEN-1:0] md_x, md_y, md_opa, md_opb;
    logic [XLEN-1:0] q_s, r_s;

    // writeback results
    result_t         r;
    logic [XLEN-1:0] val, ld_ext, csr_t, csr_wval, x_sh;
    logic            wr, ill, csr_we, ecall, ld_set;
    csr_idx_t        csr_idx;
    logic            br_t;
    logic [4:0]      sh5;

    always_comb
    begin
        op    = ins_reg[6:0];
        rd    = ins_reg[11:7];
        f3    = ins_reg[14:12];
        rs1   = ins_reg[19:15];
        rs2   = ins_reg[24:20];
        f7    = ins_reg[31:25];
        imm_i = {{52{ins_reg[31]}}, ins_reg[31:20]};
        imm_s = {{52{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
        imm_b = {{51{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                 ins_reg[11:8], 1'b0};
        imm_u = {{32{ins_reg[31]}}, ins_reg[31:12], 12'b0};
        imm_j = {{43{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                 ins_reg[30:21], 1'b0};
        // port B also serves the a7 / a0 reads of ecall and ebreak
        if (op == OPC_SYSTEM)
        begin
            rb_addr = (ins_reg == INS_EBREAK) ? REG_A0 : REG_A7;
        end
        else
        begin
            rb_addr = rs2;
        end
    end

    // mul/div operand preparation: magnitudes for signed divide
    always_comb
    begin
        md_w  = (op == OPC_OP32);
        md_x  = md_w ? (f3[0] ? {32'b0, a_reg[31:0]} : sx32(a_reg)) : a_reg;
        md_y  = md_w ? (f3[0] ? {32'b0, b_reg[31:0]} : sx32(b_reg)) : b_reg;
        md_sa = f3[2] && !f3[0] && md_x[XLEN-1];
        md_sb = f3[2] && !f3[0] && md_y[XLEN-1];
        md_bz = (md_y == '0);
        md_opa = (f3[2] && md_sa) ? -md_x : md_x;
        md_opb = (f3[2] && md_sb) ? -md_y : md_y;
        q_s   = md_bz ? '1 : ((md_sa ^ md_sb) ? -md_lo : md_lo);
        r_s   = md_sa ? -md_hi : md_hi;
        stat.md_need = !req_reg && (f7 == F7_MULDIV) &&
                       ((op == OPC_OP) ||
                        ((op == OPC_OP32) && (f3 == 3'd0 || f3[2])));
        stat.md_done = md_done;
    end

    rv64_md u_md
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .is_div (f3[2]),
        .opa    (md_opa),
        .opb    (md_opb),
        .done   (md_done),
        .hi     (md_hi),
        .lo     (md_lo)
    );

    always_comb
    begin
        unique case (ins_reg[31:20])
            CSR_SATP:    begin csr_idx = CSR_IDX_SATP;    csr_t = satp_reg;    end
            CSR_MSTATUS: begin csr_idx = CSR_IDX_MSTATUS; csr_t = mstatus_reg; end
            CSR_MEPC:    begin csr_idx = CSR_IDX_MEPC;    csr_t = mepc_reg;    end
            CSR_MCAUSE:  begin csr_idx = CSR_IDX_MCAUSE;  csr_t = mcause_reg;  end
            CSR_MTVEC:   begin csr_idx = CSR_IDX_MTVEC;   csr_t = mtvec_reg;   end
            default:     begin csr_idx = CSR_IDX_NONE;    csr_t = '0;          end
        endcase
        unique case (f3)
            3'd1:    csr_wval = a_reg;
            3'd2:    csr_wval = csr_t | a_reg;
            default: csr_wval = csr_t & ~a_reg;
        endcase
        unique case (lds_reg)
            3'd0:    ld_ext = {{56{ld_reg[7]}}, ld_reg[7:0]};
            3'd1:    ld_ext = {{48{ld_reg[15]}}, ld_reg[15:0]};
            3'd2:    ld_ext = sx32(ld_reg);
            3'd4:    ld_ext = {56'b0, ld_reg[7:0]};
            3'd5:    ld_ext = {48'b0, ld_reg[15:0]};
            3'd6:    ld_ext = {32'b0, ld_reg[31:0]};
            default: ld_ext = ld_reg;
        endcase
    end

    // main decode and execute
    always_comb
    begin
        r        = '0;
        r.next_pc = pc_reg + 64'd4;
        val      = '0;
        wr       = 1'b0;
        ill      = 1'b0;
        csr_we   = 1'b0;
        ecall    = 1'b0;
        ld_set   = 1'b0;
        br_t     = 1'b0;
        sh5      = b_reg[4:0];
        x_sh     = '0;
        unique case (op)
            OPC_LUI:
            begin
                val = imm_u; wr = 1'b1;
            end
            OPC_AUIPC:
            begin
                val = pc_reg + imm_u; wr = 1'b1;
            end
            OPC_JAL:
            begin
                val = pc_reg + 64'd4; wr = 1'b1; r.next_pc = pc_reg + imm_j;
            end
            OPC_JALR:
            begin
                if (f3 != 3'd0)
                begin
                    ill = 1'b1;
                end
                else
                begin
                    r.next_pc = (a_reg + imm_i) & ~64'd1;
                    val = pc_reg + 64'd4; wr = 1'b1;
                end
            end
            OPC_BRANCH:
            begin
                unique case (f3)
                    3'd0:    br_t = a_reg == b_reg;
                    3'd1:    br_t = a_reg != b_reg;
                    3'd4:    br_t = $signed(a_reg) < $signed(b_reg);
                    3'd5:    br_t = $signed(a_reg) >= $signed(b_reg);
                    3'd6:    br_t = a_reg < b_reg;
                    3'd7:    br_t = a_reg >= b_reg;
                    default: ill = 1'b1;
                endcase
                if (br_t)
                begin
                    r.next_pc = pc_reg + imm_b;
                end
            end
            OPC_LOAD:
            begin
                if (f3 == 3'd7)
                begin
                    ill = 1'b1;
                end
                else
                begin
                    r.status    = ST_LOAD;
                    r.mem_op    = MEM_READ;
                    r.mem_addr  = a_reg + imm_i;
                    r.mem_bytes = 4'b0001 << f3[1:0];
                    ld_set      = 1'b1;
                end
            end
            OPC_STORE:
            begin
                if (f3[2])
                begin
                    ill = 1'b1;
                end
                else
                begin
                    r.mem_op     = MEM_WRITE;
                    r.mem_addr   = a_reg + imm_s;
                    r.mem_bytes  = 4'b0001 << f3[1:0];
                    r.store_data = b_reg;
                end
            end
            OPC_IMM:
            begin
                wr = 1'b1;
                unique case (f3)
                    3'd0: val = a_reg + imm_i;
                    3'd2: val = {63'b0, $signed(a_reg) < $signed(imm_i)};
                    3'd3: val = {63'b0, a_reg < imm_i};
                    3'd4: val = a_reg ^ imm_i;
                    3'd6: val = a_reg | imm_i;
                    3'd7: val = a_reg & imm_i;
                    3'd1:
                    begin
                        if (ins_reg[31:26] != F6_SRL) ill = 1'b1;
                        else val = a_reg << ins_reg[25:20];
                    end
                    default:
                    begin
                        if (ins_reg[31:26] == F6_SRL)
                            val = a_reg >> ins_reg[25:20];
                        else if (ins_reg[31:26] == F6_SRA)
                            val = $unsigned($signed(a_reg) >>> ins_reg[25:20]);
                        else
                            ill = 1'b1;
                    end
                endcase
            end
            OPC_OP:
            begin
                wr = 1'b1;
                if (f7 == F7_BASE)
                begin
                    unique case (f3)
                        3'd0:    val = a_reg + b_reg;
                        3'd1:    val = a_reg << b_reg[5:0];
                        3'd2:    val = {63'b0, $signed(a_reg) < $signed(b_reg)};
                        3'd3:    val = {63'b0, a_reg < b_reg};
                        3'd4:    val = a_reg ^ b_reg;
                        3'd5:    val = a_reg >> b_reg[5:0];
                        3'd6:    val = a_reg | b_reg;
                        default: val = a_reg & b_reg;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                    val = a_reg - b_reg;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    val = $unsigned($signed(a_reg) >>> b_reg[5:0]);
                else if (f7 == F7_MULDIV)
                begin
                    unique case (f3)
                        3'd0:    val = md_lo;
                        3'd1:    val = md_hi - (a_reg[XLEN-1] ? b_reg : '0)
                                             - (b_reg[XLEN-1] ? a_reg : '0);
                        3'd2:    val = md_hi - (a_reg[XLEN-1] ? b_reg : '0);
                        3'd3:    val = md_hi;
                        3'd4:    val = q_s;
                        3'd5:    val = md_lo;
                        3'd6:    val = r_s;
                        default: val = md_hi;
                    endcase
                end
                else
                    ill = 1'b1;
            end
            OPC_IMM32:
            begin
                wr = 1'b1;
                if (f3 == 3'd0)
                    val = sx32(a_reg + imm_i);
                else if (f3 == 3'd1 && f7 == F7_BASE)
                    val = sx32(a_reg << rs2);
                else if (f3 == 3'd5 && f7 == F7_BASE)
                    val = sx32({32'b0, a_reg[31:0]} >> rs2);
                else if (f3 == 3'd5 && f7 == F7_ALT)
                    val = $unsigned($signed(sx32(a_reg)) >>> rs2);
                else
                    ill = 1'b1;
            end
            OPC_OP32:
            begin
                wr = 1'b1;
                x_sh = {32'b0, a_reg[31:0]};
                if (f7 == F7_BASE && f3 == 3'd0)
                    val = sx32(a_reg + b_reg);
                else if (f7 == F7_ALT && f3 == 3'd0)
                    val = sx32(a_reg - b_reg);
                else if (f7 == F7_BASE && f3 == 3'd1)
                    val = sx32(x_sh << sh5);
                else if (f7 == F7_BASE && f3 == 3'd5)
                    val = sx32(x_sh >> sh5);
                else if (f7 == F7_ALT && f3 == 3'd5)
                    val = $unsigned($signed(sx32(a_reg)) >>> sh5);
                else if (f7 == F7_MULDIV && f3 == 3'd0)
                    val = sx32(md_lo);
                else if (f7 == F7_MULDIV && f3 == 3'd4)
                    val = sx32(q_s);
                else if (f7 == F7_MULDIV && f3 == 3'd5)
                    val = sx32(md_lo);
                else if (f7 == F7_MULDIV && f3 == 3'd6)
                    val = sx32(r_s);
                else if (f7 == F7_MULDIV && f3 == 3'd7)
                    val = sx32(md_hi);
                else
                    ill = 1'b1;
            end
            OPC_SYSTEM:
            begin
                if (ins_reg == INS_ECALL)
                begin
                    ecall = 1'b1; r.next_pc = mtvec_reg; r.status = ST_ECALL;
                end
                else if (ins_reg == INS_EBREAK)
                begin
                    r.status = ST_HALT; r.halt_code = b_reg; r.next_pc = pc_reg;
                end
                else if (ins_reg == INS_MRET)
                    r.next_pc = mepc_reg + 64'd4;
                else if (f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd3)
                begin
                    if (csr_idx == CSR_IDX_NONE)
                    begin
                        r.status = ST_CSR_UNK; r.next_pc = pc_reg;
                    end
                    else
                    begin
                        csr_we = 1'b1; val = csr_t; wr = 1'b1;
                    end
                end
                else
                    ill = 1'b1;
            end
            default: ill = 1'b1;
        endcase
        if (ill)
        begin
            r         = '0;
            r.status  = ST_ILLEGAL;
            r.next_pc = pc_reg;
            wr        = 1'b0;
            csr_we    = 1'b0;
            ecall     = 1'b0;
            ld_set    = 1'b0;
        end
        // load data word: only the register write, result is all zero
        if (req_reg)
        begin
            r      = '0;
            val    = ld_ext;
            wr     = ldp_reg;
            csr_we = 1'b0;
            ecall  = 1'b0;
            ld_set = 1'b0;
        end
    end

    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type;
            ins_reg <= instr_word;
            pc_reg  <= pc_value;
            ld_reg  <= load_data;
        end
        if (cmd.read)
        begin
            a_reg <= rf_vld_reg[rs1] ? rf[rs1] : '0;
            b_reg <= rf_vld_reg[rb_addr] ? rf[rb_addr] : '0;
        end
        if (cmd.wb)
        begin
            res_reg <= r;
        end
    end

    // register file array: one write port, read at READ
    always_ff @(posedge clk)
    begin
        if (cmd.wb && wr)
        begin
            rf[req_reg ? ldd_reg : rd] <= val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg  <= '0;
            satp_reg    <= '0;
            mstatus_reg <= '0;
            mepc_reg    <= '0;
            mcause_reg  <= '0;
            mtvec_reg   <= '0;
            ldp_reg     <= 1'b0;
            ldd_reg     <= '0;
            lds_reg     <= '0;
        end
        else if (cmd.wb)
        begin
            if (wr && (req_reg ? ldd_reg : rd) != '0)
            begin
                rf_vld_reg[req_reg ? ldd_reg : rd] <= 1'b1;
            end
            ldp_reg <= ld_set;
            if (ld_set)
            begin
                ldd_reg <= rd;
                lds_reg <= f3;
            end
            if (ecall)
            begin
                mepc_reg   <= pc_reg;
                mcause_reg <= b_reg;
            end
            if (csr_we)
            begin
                unique case (csr_idx)
                    CSR_IDX_SATP:    satp_reg    <= csr_wval;
                    CSR_IDX_MSTATUS: mstatus_reg <= csr_wval;
                    CSR_IDX_MEPC:    mepc_reg    <= csr_wval;
                    CSR_IDX_MCAUSE:  mcause_reg  <= csr_wval;
                    CSR_IDX_MTVEC:   mtvec_reg   <= csr_wval;
                    default:         ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rv64_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv64_ctrl
// Sequencer: accept, operand read, optional mul/div, writeback, output valid.
// ----------------------------------------------------------------------------
module rv64_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rv64_pkg::dp_cmd_t       cmd,
    input  wire rv64_pkg::dp_stat_t stat
);
    import rv64_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_MDI, S_MD, S_WB} state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   wb_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign wb_ok     = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.latch    = (state_reg == S_IDLE) && in_valid;
        cmd.read     = (state_reg == S_READ);
        cmd.md_start = (state_reg == S_MDI);
        cmd.wb       = (state_reg == S_WB) && wb_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wb)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (in_valid) state_reg <= S_READ;
                S_READ: state_reg <= stat.md_need ? S_MDI : S_WB;
                S_MDI:  state_reg <= S_MD;
                S_MD:   if (stat.md_done) state_reg <= S_WB;
                S_WB:   if (wb_ok) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch, cmd.read, cmd.md_start, cmd.wb}))
        else $error("more than one datapath command");

    a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |=> out_valid_reg && state_reg == S_IDLE)
        else $error("writeback did not present a result");

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |=> state_reg == S_READ)
        else $error("accepted word not followed by operand read");

endmodule
`default_nettype wire

// ===== rtl/rv64im_instruction_execute_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv64im_instruction_execute_core
// RV64IM execute core with 32x64 register file, satp and four machine CSRs.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word is either an instruction (s_tuser = 0) or the
// raw data answering the previous load (s_tuser = 1). Output stream (m_*):
// one result word per input word: status, next pc, memory request, store
// data and the a0 halt code.
// A load returns status "load pending" plus a read request; the next input
// word carries the data, which is extended and written to rd.
// An ALU/branch/memory/system word passes through the accept, register-file
// read and execute+writeback states; its result is registered into the output
// register at writeback, and the next word can be accepted once the core is
// back in idle. Multiply and divide add a start state and 64 iterations of the
// shared radix-2 unit.
// One word is worked on at a time; the next word is accepted while the
// previous result still sits in the output register.
// Reset clears the register file (through per-entry valid bits), CSRs and
// the pending-load flag; no clearing pass is needed.
// If the receiver stalls, the finished word waits in writeback until the
// output register frees, and no new word is accepted meanwhile.
// ----------------------------------------------------------------------------
module rv64im_instruction_execute_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] instr_word, [95:32] pc_value, [159:96] load_data
    input  wire logic [159:0] s_tdata,
    // [0] req_type
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] status, [66:3] next_pc, [68:67] mem_op, [132:69] mem_addr,
    // [136:133] mem_bytes, [200:137] store_data, [264:201] halt_code, rest 0
    output logic [271:0]      m_tdata
);
    import rv64_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    result_t  res;

    rv64_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rv64_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (s_tuser),
        .instr_word (s_tdata[31:0]),
        .pc_value   (s_tdata[95:32]),
        .load_data  (s_tdata[159:96]),
        .res        (res)
    );

    assign m_tdata = {7'b0, res.halt_code, res.store_data, res.mem_bytes,
                      res.mem_addr, res.mem_op, res.next_pc, res.status};

endmodule
`default_nettype wire
